FILE: hdl/rbe_pkg.sv
// ----------------------------------------------------------------------------
// rbe_pkg
// Shared types and constants for the RGBA blend equation unit.
// ----------------------------------------------------------------------------
package rbe_pkg;

	localparam int unsigned CHAN_W   = 8;
	localparam int unsigned LANES    = 4;
	localparam int unsigned PROD_W   = 2 * CHAN_W;
	localparam int unsigned SUM_W    = PROD_W + 1;
	localparam int unsigned RECIP_W  = 18;
	localparam int unsigned MULQ_W   = SUM_W + RECIP_W;
	localparam int unsigned QUOT_W   = CHAN_W + 1;

	// floor(x/255) == (x * 131587) >> 25 for x < 132626
	localparam logic [RECIP_W-1:0] RECIP_255   = 18'd131587;
	localparam int unsigned        RECIP_SHIFT = 25;
	localparam logic [CHAN_W-1:0]  CHAN_MAX    = 8'd255;

	typedef enum logic [2:0] {
		MODE_ADD    = 3'd0,
		MODE_SUB    = 3'd1,
		MODE_REVSUB = 3'd2,
		MODE_MIN    = 3'd3,
		MODE_MAX    = 3'd4
	} blend_mode_t;

endpackage

FILE: hdl/rbe_lane.sv
// ----------------------------------------------------------------------------
// rbe_lane
// One color channel: products, add/subtract combine or min/max select, divide by 255, clamp.
// Three pipeline stages, one request per cycle.
// ----------------------------------------------------------------------------
module rbe_lane
	import rbe_pkg::*;
(
	input  logic              clk,
	input  blend_mode_t       mode,
	input  logic [CHAN_W-1:0] src,
	input  logic [CHAN_W-1:0] src_f,
	input  logic [CHAN_W-1:0] dst,
	input  logic [CHAN_W-1:0] dst_f,
	output logic [CHAN_W-1:0] chan_s3
);

	logic [PROD_W-1:0] ps_s1, pd_s1;
	logic [CHAN_W-1:0] s_s1, d_s1;
	blend_mode_t       mode_s1;

	logic [SUM_W-1:0]  num_s2;
	logic [CHAN_W-1:0] byp_s2;
	logic              byp_sel_s2;

	logic [SUM_W-1:0]  num_c;
	logic [CHAN_W-1:0] byp_c;
	logic              byp_sel_c;
	logic [MULQ_W-1:0] prod_c;
	logic [QUOT_W-1:0] quot_c;

	always_ff @(posedge clk) begin
		ps_s1   <= PROD_W'(src) * PROD_W'(src_f);
		pd_s1   <= PROD_W'(dst) * PROD_W'(dst_f);
		s_s1    <= src;
		d_s1    <= dst;
		mode_s1 <= mode;
	end

	always_comb begin
		num_c     = '0;
		byp_c     = '0;
		byp_sel_c = 1'b0;
		case (mode_s1)
			MODE_ADD: begin
				num_c = SUM_W'(ps_s1) + SUM_W'(pd_s1);
			end
			MODE_SUB: begin
				if (ps_s1 > pd_s1) begin
					num_c = SUM_W'(ps_s1 - pd_s1);
				end
			end
			MODE_REVSUB: begin
				if (pd_s1 > ps_s1) begin
					num_c = SUM_W'(pd_s1 - ps_s1);
				end
			end
			MODE_MIN: begin
				byp_sel_c = 1'b1;
				byp_c     = (s_s1 < d_s1) ? s_s1 : d_s1;
			end
			MODE_MAX: begin
				byp_sel_c = 1'b1;
				byp_c     = (s_s1 > d_s1) ? s_s1 : d_s1;
			end
			default: begin
				byp_sel_c = 1'b1;
				byp_c     = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		num_s2     <= num_c;
		byp_s2     <= byp_c;
		byp_sel_s2 <= byp_sel_c;
	end

	assign prod_c = MULQ_W'(num_s2) * MULQ_W'(RECIP_255);
	assign quot_c = prod_c[RECIP_SHIFT +: QUOT_W];

	always_ff @(posedge clk) begin
		if (byp_sel_s2) begin
			chan_s3 <= byp_s2;
		end else if (quot_c > QUOT_W'(CHAN_MAX)) begin
			chan_s3 <= CHAN_MAX;
		end else begin
			chan_s3 <= quot_c[CHAN_W-1:0];
		end
	end

endmodule

FILE: hdl/rbe_merge.sv
// ----------------------------------------------------------------------------
// rbe_merge
// Packs the lane results into one RGBA word and registers it with its strobe.
// ----------------------------------------------------------------------------
module rbe_merge
	import rbe_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid_s3,
	input  logic [LANES-1:0][CHAN_W-1:0] lane_chan,
	output logic                     result_valid,
	output logic [LANES*CHAN_W-1:0]  blended_color
);

	logic                    valid_q;
	logic [LANES*CHAN_W-1:0] color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			color_q <= lane_chan;
		end
	end

	assign result_valid  = valid_q;
	assign blended_color = color_q;

endmodule

FILE: hdl/rgba_blend_equation.sv
// ----------------------------------------------------------------------------
// rgba_blend_equation
// Per-channel RGBA blend: add, subtract, reverse subtract, min, max.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low. busy
//   is always low: the block takes a new request every cycle.
//   Four identical channel lanes run side by side, each with three stages
//   (8x8 products, add/subtract combine, divide by 255 via reciprocal
//   multiply and clamp); a merge stage packs and registers the RGBA word.
//   blended_color is valid for one cycle with result_valid high, once the
//   request has passed the three lane stages and the merge register.
//   Throughput is one pixel per cycle. The receiver cannot stall; results
//   are never held back. blend_mode must be written with blend_mode_we only
//   while no request is in flight; the block itself does not enforce this.
//   Codes 5..7 produce a black, zero-alpha result. Reset clears blend_mode
//   to add and drops all in-flight requests.
// ----------------------------------------------------------------------------
module rgba_blend_equation
	import rbe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        blend_mode_we,
	input  logic [2:0]  blend_mode,
	input  logic [31:0] source_color,
	input  logic [31:0] source_factor,
	input  logic [31:0] dest_color,
	input  logic [31:0] dest_factor,
	output logic        result_valid,
	output logic [31:0] blended_color
);

	blend_mode_t                  blend_mode_q;
	logic                         valid_s1, valid_s2, valid_s3;
	logic [LANES-1:0][CHAN_W-1:0] lane_chan;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q <= MODE_ADD;
		end else if (blend_mode_we) begin
			blend_mode_q <= blend_mode_t'(blend_mode);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		rbe_lane u_lane (
			.clk     (clk),
			.mode    (blend_mode_q),
			.src     (source_color [i*CHAN_W +: CHAN_W]),
			.src_f   (source_factor[i*CHAN_W +: CHAN_W]),
			.dst     (dest_color   [i*CHAN_W +: CHAN_W]),
			.dst_f   (dest_factor  [i*CHAN_W +: CHAN_W]),
			.chan_s3 (lane_chan[i])
		);
	end

	rbe_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s3      (valid_s3),
		.lane_chan     (lane_chan),
		.result_valid  (result_valid),
		.blended_color (blended_color)
	);

endmodule

FILE: tb/sv/rgba_blend_equation_tb.sv
// ----------------------------------------------------------------------------
// rgba_blend_equation_tb
// Self-checking bench for the RGBA blend unit. A short table of directed
// pixels (channel extremes, every equation, clamping, undefined codes) is
// followed by random pixels in bursts under several blend modes. Each result
// is compared, in request order, with a table value or a per-channel blend predictor.
// ----------------------------------------------------------------------------
module rgba_blend_equation_tb;
	import rbe_pkg::*;

	localparam logic [2:0]  MODE_RSVD5   = 3'd5;
	localparam logic [2:0]  MODE_RSVD6   = 3'd6;
	localparam logic [2:0]  MODE_RSVD7   = 3'd7;
	localparam int unsigned CHANNEL_FULL = 255;
	localparam int unsigned STALL_LIMIT  = 1000;
	localparam int unsigned REPORT_MAX   = 10;
	localparam int unsigned N_DIRECTED   = 22;
	localparam int unsigned N_PHASES     = 11;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] src;
		logic [31:0] src_f;
		logic [31:0] dst;
		logic [31:0] dst_f;
		logic        known;
		logic [31:0] want;
	} blend_row_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        start         = 1'b0;
	logic        blend_mode_we = 1'b0;
	logic [2:0]  blend_mode    = 3'd0;
	logic [31:0] source_color  = '0;
	logic [31:0] source_factor = '0;
	logic [31:0] dest_color    = '0;
	logic [31:0] dest_factor   = '0;
	logic        busy;
	logic        result_valid;
	logic [31:0] blended_color;

	logic [31:0]  expected_colors [$];
	logic [2:0]   active_mode = MODE_ADD;
	int unsigned  mismatches  = 0;

	blend_row_t directed_rows [0:N_DIRECTED-1] = '{
		'{MODE_ADD,    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000},
		'{MODE_ADD,    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
		'{MODE_ADD,    32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h00000000, 1'b1, 32'hFFFFFFFF},
		'{MODE_ADD,    32'h12345678, 32'h80FF0040, 32'h9ABCDEF0, 32'h7F00FF01, 1'b0, 32'h0},
		'{MODE_ADD,    32'hFFFFFFFF, 32'hFF00FF00, 32'hFFFFFFFF, 32'h01FF00FF, 1'b0, 32'h0},
		'{MODE_SUB,    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h00000000},
		'{MODE_SUB,    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF},
		'{MODE_SUB,    32'h00000000, 32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h00000000},
		'{MODE_SUB,    32'hC0407F81, 32'hFE02A55A, 32'h3FBF807E, 32'h01FD5AA5, 1'b0, 32'h0},
		'{MODE_REVSUB, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h00000000, 1'b1, 32'h00000000},
		'{MODE_REVSUB, 32'h00000000, 32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
		'{MODE_REVSUB, 32'h3FBF807E, 32'h01FD5AA5, 32'hC0407F81, 32'hFE02A55A, 1'b0, 32'h0},
		'{MODE_MIN,    32'hFF00FF00, 32'hFFFFFFFF, 32'h00FF00FF, 32'h00000000, 1'b1, 32'h00000000},
		'{MODE_MIN,    32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF},
		'{MODE_MIN,    32'h807F01FE, 32'h5A5A5A5A, 32'h7F8002FD, 32'hA5A5A5A5, 1'b0, 32'h0},
		'{MODE_MAX,    32'hFF00FF00, 32'h00000000, 32'h00FF00FF, 32'h00000000, 1'b1, 32'hFFFFFFFF},
		'{MODE_MAX,    32'h00000000, 32'hFFFFFFFF, 32'h00000000, 32'hFFFFFFFF, 1'b1, 32'h00000000},
		'{MODE_MAX,    32'h807F01FE, 32'h5A5A5A5A, 32'h7F8002FD, 32'hA5A5A5A5, 1'b0, 32'h0},
		'{MODE_RSVD5,  32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h00000000},
		'{MODE_RSVD6,  32'h12345678, 32'h9ABCDEF0, 32'h0F1E2D3C, 32'h4B5A6978, 1'b1, 32'h00000000},
		'{MODE_RSVD7,  32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'h00000000},
		'{MODE_ADD,    32'hA5C3E187, 32'h7E81FF3C, 32'h5A3C1E78, 32'hC37E00FF, 1'b0, 32'h0}
	};

	logic [2:0] phase_modes [0:N_PHASES-1] = '{
		MODE_ADD, MODE_SUB, MODE_REVSUB, MODE_MIN, MODE_MAX,
		MODE_RSVD5, MODE_RSVD7, MODE_ADD, MODE_RSVD6, MODE_MAX, MODE_SUB
	};

	rgba_blend_equation uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.blend_mode_we (blend_mode_we),
		.blend_mode    (blend_mode),
		.source_color  (source_color),
		.source_factor (source_factor),
		.dest_color    (dest_color),
		.dest_factor   (dest_factor),
		.result_valid  (result_valid),
		.blended_color (blended_color)
	);

	always #4 clk = ~clk;

	function automatic logic [31:0] blend_pixel(input logic [2:0] mode,
		input logic [31:0] sc, input logic [31:0] sf,
		input logic [31:0] dc, input logic [31:0] df);
		logic [31:0] px;
		logic [7:0]  s, d, lane;
		logic [15:0] ps, pd;
		logic [16:0] q;
		int          k;
		px = '0;
		for (k = 0; k < 4; k++) begin
			s  = sc[8*k +: 8];
			d  = dc[8*k +: 8];
			ps = 16'(s) * 16'(sf[8*k +: 8]);
			pd = 16'(d) * 16'(df[8*k +: 8]);
			case (mode)
				MODE_ADD: begin
					q    = 17'(({1'b0, ps} + {1'b0, pd}) / CHANNEL_FULL);
					lane = (q > CHANNEL_FULL) ? 8'hFF : q[7:0];
				end
				MODE_SUB: begin
					q    = (ps > pd) ? 17'((ps - pd) / CHANNEL_FULL) : 17'd0;
					lane = q[7:0];
				end
				MODE_REVSUB: begin
					q    = (pd > ps) ? 17'((pd - ps) / CHANNEL_FULL) : 17'd0;
					lane = q[7:0];
				end
				MODE_MIN: lane = (s < d) ? s : d;
				MODE_MAX: lane = (s > d) ? s : d;
				default:  lane = 8'h00;
			endcase
			px[8*k +: 8] = lane;
		end
		return px;
	endfunction

	// channels lean toward 0, 1, 254 and 255 to hit clamping often
	function automatic logic [31:0] rand_rgba();
		logic [31:0] w;
		int          k;
		w = $urandom;
		for (k = 0; k < 4; k++) begin
			case ($urandom_range(0, 7))
				0: w[8*k +: 8] = 8'h00;
				1: w[8*k +: 8] = 8'hFF;
				2: w[8*k +: 8] = 8'h01;
				3: w[8*k +: 8] = 8'hFE;
				default: ;
			endcase
		end
		return w;
	endfunction

	task automatic send_pixel(input logic [31:0] sc, input logic [31:0] sf,
		input logic [31:0] dc, input logic [31:0] df, input logic [31:0] want);
		start         <= 1'b1;
		source_color  <= sc;
		source_factor <= sf;
		dest_color    <= dc;
		dest_factor   <= df;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_colors.push_back(want);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (expected_colors.size() != 0) @(posedge clk);
	endtask

	task automatic write_mode(input logic [2:0] mode);
		drain_results();
		blend_mode_we <= 1'b1;
		blend_mode    <= mode;
		@(posedge clk);
		blend_mode_we <= 1'b0;
		active_mode = mode;
	endtask

	task automatic note_mismatch(input logic [31:0] want, input logic [31:0] got,
		input logic have_want);
		mismatches++;
		if (mismatches <= REPORT_MAX) begin
			if (have_want)
				$display("mismatch: blended_color expected %h got %h", want, got);
			else
				$display("mismatch: unexpected result %h", got);
		end
	endtask

	always @(posedge clk) begin : check_results
		logic [31:0] want;
		if (result_valid === 1'b1) begin
			if (expected_colors.size() == 0) begin
				note_mismatch('0, blended_color, 1'b0);
			end else begin
				want = expected_colors.pop_front();
				if (blended_color !== want)
					note_mismatch(want, blended_color, 1'b1);
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || result_valid === 1'b1)
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		blend_row_t  row;
		logic [31:0] sc, sf, dc, df;
		int unsigned items, sent, burst, gap, p, r;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < N_DIRECTED; r++) begin
			row = directed_rows[r];
			if (row.mode != active_mode)
				write_mode(row.mode);
			send_pixel(row.src, row.src_f, row.dst, row.dst_f,
				row.known ? row.want
				          : blend_pixel(active_mode, row.src, row.src_f, row.dst, row.dst_f));
		end

		for (p = 0; p < N_PHASES + 1; p++) begin
			if (p < N_PHASES)
				write_mode(phase_modes[p]);
			else
				write_mode(3'($urandom_range(MODE_ADD, MODE_MAX)));
			items = (active_mode > MODE_MAX) ? 25 : 95;
			sent  = 0;
			while (sent < items) begin
				burst = $urandom_range(1, 40);
				while (burst != 0 && sent < items) begin
					sc = rand_rgba();
					sf = rand_rgba();
					dc = rand_rgba();
					df = rand_rgba();
					send_pixel(sc, sf, dc, df, blend_pixel(active_mode, sc, sf, dc, df));
					burst--;
					sent++;
				end
				case ($urandom_range(0, 7))
					0, 1: ;
					2: drain_results();
					default: begin
						gap = $urandom_range(1, 6);
						start <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				endcase
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		mismatches += expected_colors.size();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
